@@ design/bte_pkg.sv @@
// Shared types and constants for the bit store with test/set/clear and word listing.
// Used by the scanner, the top level, the checker and the bench; has no dependencies of its own.
package bte_pkg;

    localparam int WORD_BITS  = 64;
    localparam int OFF_BITS   = 6;
    localparam int WIDX_BITS  = 6;
    localparam int BIDX_BITS  = 12;
    localparam int WCNT_BITS  = 7;

    localparam logic [WCNT_BITS-1:0] WORD_COUNT_RST = 7'd64;

    localparam logic [1:0] OP_TEST  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_LIST  = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic [BIDX_BITS-1:0] bit_addr;
        logic [WIDX_BITS-1:0] word_index;
    } t_in_word;

    typedef struct packed {
        logic                 prior_bit;
        logic [BIDX_BITS-1:0] set_index;
        logic                 found;
        logic                 last;
        logic                 range_error;
    } t_out_word;

    typedef struct packed {
        logic                 load;
        logic                 advance;
        logic [WORD_BITS-1:0] word;
    } t_scan_ctl;

    typedef struct packed {
        logic                empty;
        logic [OFF_BITS-1:0] pos;
        logic                is_last;
    } t_scan_sts;

endpackage

@@ design/bte_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bte_scan.sv @@
// Set-bit scanner: holds one word, reports its lowest set bit and strips it per step.
// Depends on bte_pkg.
module bte_scan (
    input  logic               i_clk,
    input  bte_pkg::t_scan_ctl i_ctl,
    output bte_pkg::t_scan_sts o_sts
);

    logic [bte_pkg::WORD_BITS-1:0] r_word;
    logic [bte_pkg::WORD_BITS-1:0] lowbit;
    logic [bte_pkg::WORD_BITS-1:0] rest;
    logic [bte_pkg::OFF_BITS-1:0]  pos;

    // isolate lowest set bit, then encode it
    assign lowbit = r_word & (~r_word + bte_pkg::WORD_BITS'(1));
    assign rest   = r_word & ~lowbit;

    always_comb begin
        pos = '0;
        for (int i = 0; i < bte_pkg::WORD_BITS; i++) begin
            if (lowbit[i]) begin
                pos = pos | bte_pkg::OFF_BITS'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_word <= i_ctl.word;
        end else if (i_ctl.advance) begin
            r_word <= rest;
        end
    end

    assign o_sts.empty   = (r_word == '0);
    assign o_sts.pos     = pos;
    assign o_sts.is_last = (rest == '0);

endmodule

@@ design/bitset_test_set_enumerate.sv @@
// Bit store top level: test, test-and-set, test-and-clear, and listing of a word's set bits.
// Single-bit ops: each word in is accepted, read from the RAM (set and clear write it back), one result.
// Listing: the word is read, then one result per set bit from the scanner, or one if none.
// One item in flight; the RAM's registered read port adds a read state before any result.
// Reset (i_rst_n low, synchronous) clears control, word_count to 64 and all per-word valid
// bits, so the store reads as empty at once; there is no clearing pass.
module bitset_test_set_enumerate #(
    parameter int STORE_WORDS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bte_pkg::WCNT_BITS-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bte_pkg::t_in_word                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bte_pkg::t_out_word                o_out_data
);

    localparam int AW      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int VALID_N = (STORE_WORDS < 64) ? STORE_WORDS : 64;
    localparam int VW      = (VALID_N > 1) ? $clog2(VALID_N) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0]                           r_state, n_state;
    logic [1:0]                           r_op;
    logic [bte_pkg::WIDX_BITS-1:0]        r_word;
    logic [bte_pkg::OFF_BITS-1:0]         r_off;
    logic                                 r_err;
    logic [VALID_N-1:0]                   r_valid, n_valid;
    logic [bte_pkg::WCNT_BITS-1:0]        r_word_count;
    logic                                 r_out_valid, n_out_valid;
    bte_pkg::t_out_word                   r_out, n_out;

    logic                                 accept;
    logic [bte_pkg::WIDX_BITS-1:0]        in_word;
    logic                                 in_range;
    logic                                 slot_free;
    logic                                 emit;
    logic [bte_pkg::WORD_BITS-1:0]        ram_rdata;
    logic [bte_pkg::WORD_BITS-1:0]        rd_eff;
    logic [bte_pkg::WORD_BITS-1:0]        mask;
    logic                                 ram_we;
    logic [bte_pkg::WORD_BITS-1:0]        ram_wdata;
    bte_pkg::t_scan_ctl                   scan_ctl;
    bte_pkg::t_scan_sts                   scan_sts;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign in_word    = (i_in_data.op == bte_pkg::OP_LIST) ? i_in_data.word_index
                        : i_in_data.bit_addr[bte_pkg::BIDX_BITS-1:bte_pkg::OFF_BITS];
    assign in_range   = ({1'b0, in_word} < r_word_count) && (int'(in_word) < STORE_WORDS);
    assign slot_free  = !r_out_valid || i_out_ready;

    // entries never written read as zero
    assign rd_eff = r_valid[VW'(r_word)] ? ram_rdata : '0;
    assign mask   = bte_pkg::WORD_BITS'(1) << r_off;

    bte_ram #(
        .WIDTH(bte_pkg::WORD_BITS),
        .DEPTH(STORE_WORDS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(AW'(r_word)),
        .i_wdata(ram_wdata),
        .i_re   (accept && in_range),
        .i_raddr(AW'(in_word)),
        .o_rdata(ram_rdata)
    );

    bte_scan u_scan (
        .i_clk(i_clk),
        .i_ctl(scan_ctl),
        .o_sts(scan_sts)
    );

    always_comb begin
        n_state          = r_state;
        n_valid          = r_valid;
        n_out            = r_out;
        emit             = 1'b0;
        ram_we           = 1'b0;
        ram_wdata        = (r_op == bte_pkg::OP_SET) ? (rd_eff | mask) : (rd_eff & ~mask);
        scan_ctl.load    = 1'b0;
        scan_ctl.advance = 1'b0;
        scan_ctl.word    = rd_eff;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_err) begin
                    if (slot_free) begin
                        emit              = 1'b1;
                        n_out             = '0;
                        n_out.last        = 1'b1;
                        n_out.range_error = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else if (r_op == bte_pkg::OP_LIST) begin
                    scan_ctl.load = 1'b1;
                    n_state       = S_LIST;
                end else if (slot_free) begin
                    emit            = 1'b1;
                    n_out           = '0;
                    n_out.prior_bit = rd_eff[r_off];
                    n_out.last      = 1'b1;
                    if (r_op == bte_pkg::OP_SET || r_op == bte_pkg::OP_CLEAR) begin
                        ram_we              = 1'b1;
                        n_valid[VW'(r_word)] = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (slot_free) begin
                    emit  = 1'b1;
                    n_out = '0;
                    if (scan_sts.empty) begin
                        n_out.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_out.set_index  = {r_word, scan_sts.pos};
                        n_out.found      = 1'b1;
                        n_out.last       = scan_sts.is_last;
                        scan_ctl.advance = 1'b1;
                        if (scan_sts.is_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_word_count <= bte_pkg::WORD_COUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_word_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_in_data.op;
            r_word <= in_word;
            r_off  <= i_in_data.bit_addr[bte_pkg::OFF_BITS-1:0];
            r_err  <= !in_range;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/bte_checker.sv @@
// Port-level checks for the bit store top level, attached by bind.
// Depends on bte_pkg and bitset_test_set_enumerate.
module bte_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input bte_pkg::t_out_word            o_out_data
);

    // a held result word must not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted twice in a row");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.range_error |->
            o_out_data.last && !o_out_data.found && !o_out_data.prior_bit
            && (o_out_data.set_index == '0))
        else $error("range error word malformed");

    a_found_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |->
            !o_out_data.prior_bit && !o_out_data.range_error)
        else $error("listing word malformed");

    a_notfound_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.last && (o_out_data.set_index == '0))
        else $error("non-listing word must be last with zero index");

endmodule

bind bitset_test_set_enumerate bte_checker u_bte_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

@@ bench/bitset_test_set_enumerate_tb.sv @@
// Self-checking bench for bitset_test_set_enumerate: directed and random words, random
// idling on both sides, a long output stall and word_count changes. Depends on bte_pkg
// and the block's RTL only.
module bitset_test_set_enumerate_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int REPORT_MAX  = 10;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               cfg_we      = 1'b0;
    logic [bte_pkg::WCNT_BITS-1:0] cfg_data = '0;
    logic               in_valid    = 1'b0;
    bte_pkg::t_in_word  in_data     = '0;
    logic               out_ready   = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    bte_pkg::t_out_word o_out_data;

    // shadow of the block's state
    logic [bte_pkg::WORD_BITS-1:0] shadow_words [64];
    logic [bte_pkg::WCNT_BITS-1:0] shadow_word_count;

    bte_pkg::t_out_word awaited_results [$];
    logic [5:0] hot_words [4];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int stall_request   = 0;
    int stall_left      = 0;
    int cycle_count     = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int listed_bits     = 0;
    int range_errors    = 0;
    int mismatch_count  = 0;

    bitset_test_set_enumerate uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: random idling, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (stall_request != 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        bte_pkg::t_out_word exp_w;
        if (i_rst_n && o_out_valid && out_ready) begin
            results_checked++;
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("Unexpected result word %p at cycle %0d", o_out_data, cycle_count);
            end else begin
                exp_w = awaited_results.pop_front();
                if (o_out_data.prior_bit !== exp_w.prior_bit
                        || o_out_data.set_index !== exp_w.set_index
                        || o_out_data.found !== exp_w.found
                        || o_out_data.last !== exp_w.last
                        || o_out_data.range_error !== exp_w.range_error) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"Mismatch at cycle %0d: exp prior=%0b idx=%0d found=%0b ",
                                  "last=%0b err=%0b, got prior=%0b idx=%0d found=%0b last=%0b ",
                                  "err=%0b"}, cycle_count,
                                 exp_w.prior_bit, exp_w.set_index, exp_w.found, exp_w.last,
                                 exp_w.range_error, o_out_data.prior_bit,
                                 o_out_data.set_index, o_out_data.found, o_out_data.last,
                                 o_out_data.range_error);
                end
            end
        end
    end

    // Works out the result words one accepted word causes and updates the shadow store.
    task automatic compute_bitset_results(input bte_pkg::t_in_word w);
        bte_pkg::t_out_word r;
        int        usable;
        logic [5:0] word_sel;
        logic [bte_pkg::WORD_BITS-1:0] bits;
        usable = (shadow_word_count > 64) ? 64 : int'(shadow_word_count);
        word_sel = (w.op == bte_pkg::OP_LIST) ? w.word_index : w.bit_addr[11:6];
        r = '0;
        r.last = 1'b1;
        if (int'(word_sel) >= usable) begin
            r.range_error = 1'b1;
            range_errors++;
            awaited_results.push_back(r);
        end else if (w.op == bte_pkg::OP_LIST) begin
            bits = shadow_words[word_sel];
            if (bits == '0) begin
                awaited_results.push_back(r);
            end else begin
                for (int pos = 0; pos < bte_pkg::WORD_BITS; pos++) begin
                    if (bits[pos]) begin
                        r.set_index = {word_sel, 6'(pos)};
                        r.found = 1'b1;
                        r.last = (pos == 63) || ((bits >> pos) >> 1) == '0;
                        awaited_results.push_back(r);
                        listed_bits++;
                    end
                end
            end
        end else begin
            r.prior_bit = shadow_words[word_sel][w.bit_addr[5:0]];
            if (w.op == bte_pkg::OP_SET)
                shadow_words[word_sel][w.bit_addr[5:0]] = 1'b1;
            else if (w.op == bte_pkg::OP_CLEAR)
                shadow_words[word_sel][w.bit_addr[5:0]] = 1'b0;
            awaited_results.push_back(r);
        end
    endtask

    // Offers one word after a random gap and returns at the edge that accepts it.
    // Valid is left high; the next call or drain_block decides whether it drops.
    task automatic send_word(input bte_pkg::t_in_word w);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
        compute_bitset_results(w);
    endtask

    task automatic send_op(input logic [1:0] op, input int bit_idx, input int word_idx);
        bte_pkg::t_in_word w;
        w.op = op;
        w.bit_addr = bte_pkg::BIDX_BITS'(bit_idx);
        w.word_index = bte_pkg::WIDX_BITS'(word_idx);
        send_word(w);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_word_count(input logic [bte_pkg::WCNT_BITS-1:0] value);
        drain_block();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        shadow_word_count = value;
    endtask

    function automatic bte_pkg::t_in_word random_word();
        bte_pkg::t_in_word w;
        int       pick;
        pick = $urandom_range(99);
        w.op = (pick < 20) ? bte_pkg::OP_TEST : (pick < 55) ? bte_pkg::OP_SET
               : (pick < 70) ? bte_pkg::OP_CLEAR : bte_pkg::OP_LIST;
        w.bit_addr = bte_pkg::BIDX_BITS'($urandom);
        w.word_index = bte_pkg::WIDX_BITS'($urandom);
        // keep most traffic on a few words so listings come back long
        if ($urandom_range(99) < 75) begin
            w.bit_addr[11:6] = hot_words[$urandom_range(3)];
            w.word_index = hot_words[$urandom_range(3)];
        end
        return w;
    endfunction

    task automatic test_reset_state();
        send_op(bte_pkg::OP_TEST, 4095, 0);
        send_op(bte_pkg::OP_LIST, 0, 0);
        send_op(bte_pkg::OP_LIST, 0, 63);
    endtask

    task automatic test_single_bit_ops();
        send_op(bte_pkg::OP_SET, 0, 0);
        send_op(bte_pkg::OP_TEST, 0, 0);
        send_op(bte_pkg::OP_SET, 0, 0);
        send_op(bte_pkg::OP_SET, 4095, 0);
        send_op(bte_pkg::OP_CLEAR, 4095, 0);
        send_op(bte_pkg::OP_CLEAR, 4095, 0);
        send_op(bte_pkg::OP_SET, 63, 0);
        send_op(bte_pkg::OP_SET, 64, 0);
        send_op(bte_pkg::OP_SET, 4095, 0);
    endtask

    task automatic test_listing();
        send_op(bte_pkg::OP_LIST, 4095, 0);   // bits 0 and 63
        send_op(bte_pkg::OP_LIST, 0, 1);
        send_op(bte_pkg::OP_LIST, 0, 63);     // top bit only: ends on position 63
        send_op(bte_pkg::OP_LIST, 0, 5);      // empty word
    endtask

    task automatic test_range_limits();
        write_word_count(7'd1);
        send_op(bte_pkg::OP_TEST, 64, 0);
        send_op(bte_pkg::OP_SET, 130, 0);
        send_op(bte_pkg::OP_LIST, 0, 1);
        send_op(bte_pkg::OP_LIST, 0, 0);
        write_word_count(7'd0);
        send_op(bte_pkg::OP_TEST, 0, 0);
        send_op(bte_pkg::OP_CLEAR, 0, 0);
        send_op(bte_pkg::OP_LIST, 0, 0);
        write_word_count(7'd127);
        send_op(bte_pkg::OP_TEST, 4095, 63);
        send_op(bte_pkg::OP_LIST, 0, 2);      // must still be empty after the rejected set
        write_word_count(7'd64);
    endtask

    task automatic test_full_word();
        logic [5:0] target;
        target = 6'($urandom_range(63));
        for (int b = 0; b < bte_pkg::WORD_BITS; b++)
            send_op(bte_pkg::OP_SET, {target, 6'(b)}, 0);
        send_op(bte_pkg::OP_LIST, 0, target);
        for (int b = 0; b < bte_pkg::WORD_BITS; b += 2)
            send_op(bte_pkg::OP_CLEAR, {target, 6'(b)}, 0);
        send_op(bte_pkg::OP_LIST, 0, target);
    endtask

    // Output held off while words keep coming, so the block fills and drops o_in_ready.
    task automatic test_backpressure();
        send_idle_pct = 0;
        drain_block();
        stall_request = 400;
        for (int b = 0; b < 40; b += 3)
            send_op(bte_pkg::OP_SET, 10 * 64 + b, 0);
        for (int k = 0; k < 8; k++)
            send_op(bte_pkg::OP_LIST, 0, 10);
        drain_block();
    endtask

    task automatic test_random_traffic(input int n_words, input int s_idle, input int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int k = 0; k < 4; k++)
            hot_words[k] = 6'($urandom_range(63));
        for (int k = 0; k < n_words; k++)
            send_word(random_word());
    endtask

    initial begin
        for (int k = 0; k < 64; k++)
            shadow_words[k] = '0;
        shadow_word_count = bte_pkg::WORD_COUNT_RST;
        send_idle_pct = 24;
        recv_idle_pct = 51;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_single_bit_ops();
        test_listing();
        test_range_limits();
        test_full_word();
        test_backpressure();

        test_random_traffic(50, 24, 51);
        write_word_count(7'($urandom_range(2, 63)));
        test_random_traffic(50, 51, 24);
        write_word_count(7'd127);
        test_random_traffic(40, 0, 0);
        write_word_count(7'($urandom_range(1, 64)));
        test_random_traffic(15, 0, 0);

        drain_block();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d words, checked %0d results: %0d listed set bits, %0d range errors.",
                 words_sent, results_checked, listed_bits, range_errors);
        $display("Mismatches: %0d, results still awaited: %0d",
                 mismatch_count, awaited_results.size());
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
